// ----- rtl/hvr_pkg.sv -----
package hvr_pkg;

  typedef enum logic [2:0] {
    REQ_UPDATE  = 3'd0,
    REQ_ENABLE  = 3'd1,
    REQ_DISABLE = 3'd2,
    REQ_MANUAL  = 3'd3,
    REQ_KICK    = 3'd4,
    REQ_CLOSE   = 3'd5
  } req_t;

  typedef enum logic [1:0] {
    DRV_LOW  = 2'd0,
    DRV_FULL = 2'd1,
    DRV_PWM  = 2'd2
  } drive_t;

  localparam logic [2:0] CFG_SETPOINT    = 3'd0;
  localparam logic [2:0] CFG_HYSTERESIS  = 3'd1;
  localparam logic [2:0] CFG_MIN_OPEN    = 3'd2;
  localparam logic [2:0] CFG_KA_ENABLE   = 3'd3;
  localparam logic [2:0] CFG_KA_PERIOD   = 3'd4;
  localparam logic [2:0] CFG_PWM_ENABLE  = 3'd5;
  localparam logic [2:0] CFG_PWM_DUTY    = 3'd6;
  localparam logic [2:0] CFG_PWM_FULL_ON = 3'd7;

  localparam logic [14:0] RST_SETPOINT    = 15'd0;
  localparam logic [14:0] RST_HYSTERESIS  = 15'd256;
  localparam logic [15:0] RST_MIN_OPEN    = 16'd100;
  localparam logic [31:0] RST_KA_PERIOD   = 32'd1000;
  localparam logic [7:0]  RST_PWM_DUTY    = 8'd128;
  localparam logic [15:0] RST_PWM_FULL_ON = 16'd100;

  typedef struct packed {
    logic [14:0] setpoint;
    logic [14:0] hysteresis;
    logic [15:0] min_open_ms;
    logic        ka_enable;
    logic [31:0] ka_period_ms;
    logic        pwm_enable;
    logic [7:0]  pwm_duty;
    logic [15:0] pwm_full_on_ms;
  } cfg_t;

  typedef struct packed {
    logic               reg_en;
    logic               manual;
    logic               is_open;
    drive_t             drive;
    logic [31:0]        last_open;
    logic [31:0]        last_kick;
    logic signed [15:0] held_pressure;
  } state_t;

  typedef struct packed {
    logic refused;
    logic tripped;
  } flags_t;

endpackage

// ----- rtl/hvr_step.sv -----
module hvr_step (
  input  hvr_pkg::cfg_t       cfg,
  input  hvr_pkg::state_t     st,
  input  logic [2:0]          req_type,
  input  logic [31:0]         now_ms,
  input  logic                pressure_valid,
  input  logic signed [15:0]  pressure,
  output hvr_pkg::state_t     st_nxt,
  output hvr_pkg::flags_t     flags
);

  logic [31:0]        since_kick;
  logic [31:0]        since_open;
  logic [31:0]        open_elapsed;
  logic signed [17:0] band_lo;
  logic signed [17:0] band_hi;
  logic signed [17:0] p_ext;
  logic signed [15:0] p_cur;
  logic               open_req;

  assign since_kick   = now_ms - st.last_kick;
  assign since_open   = now_ms - st.last_open;
  // a fresh opening stamps now, so its elapsed time is zero
  assign open_elapsed = st.is_open ? since_open : 32'd0;
  assign band_lo = $signed({3'b000, cfg.setpoint}) - $signed({3'b000, cfg.hysteresis});
  assign band_hi = $signed({3'b000, cfg.setpoint}) + $signed({3'b000, cfg.hysteresis});
  assign p_cur   = pressure_valid ? pressure : st.held_pressure;
  assign p_ext   = 18'(p_cur);

  always_comb begin
    st_nxt   = st;
    flags    = '0;
    open_req = 1'b0;
    case (hvr_pkg::req_t'(req_type))
      hvr_pkg::REQ_UPDATE: begin
        st_nxt.held_pressure = p_cur;
        if (st.is_open && cfg.ka_enable && since_kick > cfg.ka_period_ms) begin
          st_nxt.reg_en  = 1'b0;
          st_nxt.manual  = 1'b0;
          st_nxt.is_open = 1'b0;
          st_nxt.drive   = hvr_pkg::DRV_LOW;
          flags.tripped  = 1'b1;
        end else if (!st.reg_en) begin
          open_req = st.manual;
        end else if (p_ext < band_lo) begin
          open_req = 1'b1;
        end else if (p_ext > band_hi) begin
          st_nxt.manual  = 1'b0;
          st_nxt.is_open = 1'b0;
          st_nxt.drive   = hvr_pkg::DRV_LOW;
        end
      end
      hvr_pkg::REQ_ENABLE: begin
        st_nxt.reg_en    = 1'b1;
        st_nxt.last_kick = now_ms;
      end
      hvr_pkg::REQ_DISABLE: begin
        st_nxt.reg_en  = 1'b0;
        st_nxt.manual  = 1'b0;
        st_nxt.is_open = 1'b0;
        st_nxt.drive   = hvr_pkg::DRV_LOW;
      end
      hvr_pkg::REQ_MANUAL: begin
        if (!st.reg_en) begin
          st_nxt.manual = 1'b1;
          open_req      = 1'b1;
        end
      end
      hvr_pkg::REQ_KICK: begin
        st_nxt.last_kick = now_ms;
      end
      hvr_pkg::REQ_CLOSE: begin
        st_nxt.manual  = 1'b0;
        st_nxt.is_open = 1'b0;
        st_nxt.drive   = hvr_pkg::DRV_LOW;
      end
      default: begin
      end
    endcase

    if (open_req) begin
      if (!st.is_open && since_open < {16'd0, cfg.min_open_ms}) begin
        flags.refused = 1'b1;
      end else begin
        if (!st.is_open) begin
          st_nxt.last_open = now_ms;
        end
        st_nxt.is_open = 1'b1;
        if (!cfg.pwm_enable || open_elapsed < {16'd0, cfg.pwm_full_on_ms}) begin
          st_nxt.drive = hvr_pkg::DRV_FULL;
        end else begin
          st_nxt.drive = hvr_pkg::DRV_PWM;
        end
      end
    end
  end

endmodule

// ----- rtl/hysteresis_valve_regulator_core.sv -----
// An accepted item waits in the input register, then its result in the result register.
// Throughput: one item per cycle while out_ready is high; the single-pass step logic
// sets this. While a result waits, an empty input register can still take one item.
// Reset (synchronous, rst_n low): both stages empty, regulator disabled, valve
// closed, timestamps and held pressure zero, registers at their documented defaults.
module hysteresis_valve_regulator_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         in_req_type,
  input  logic [31:0]        in_now_ms,
  input  logic               in_pressure_valid,
  input  logic signed [15:0] in_pressure,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_valve_drive,
  output logic [7:0]         out_drive_duty,
  output logic               out_regulator_on,
  output logic               out_manual_active,
  output logic               out_open_refused,
  output logic               out_keepalive_tripped,
  output logic signed [15:0] out_latest_pressure
);

  hvr_pkg::cfg_t   cfg_r;
  hvr_pkg::state_t st_r;
  hvr_pkg::state_t st_nxt;
  hvr_pkg::flags_t flags;

  logic               v1_r;
  logic [2:0]         req_r;
  logic [31:0]        now_r;
  logic               pvalid_r;
  logic signed [15:0] pressure_r;

  logic               ov_r;
  logic [1:0]         drive_r;
  logic [7:0]         duty_r;
  logic               reg_on_r;
  logic               manual_r;
  logic               refused_r;
  logic               tripped_r;
  logic signed [15:0] latest_r;

  logic advance;
  logic step;

  assign advance  = out_ready || !ov_r;
  assign step     = v1_r && advance;
  assign in_ready = !v1_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.setpoint       <= hvr_pkg::RST_SETPOINT;
      cfg_r.hysteresis     <= hvr_pkg::RST_HYSTERESIS;
      cfg_r.min_open_ms    <= hvr_pkg::RST_MIN_OPEN;
      cfg_r.ka_enable      <= 1'b0;
      cfg_r.ka_period_ms   <= hvr_pkg::RST_KA_PERIOD;
      cfg_r.pwm_enable     <= 1'b0;
      cfg_r.pwm_duty       <= hvr_pkg::RST_PWM_DUTY;
      cfg_r.pwm_full_on_ms <= hvr_pkg::RST_PWM_FULL_ON;
    end else if (cfg_we) begin
      case (cfg_index)
        hvr_pkg::CFG_SETPOINT:    cfg_r.setpoint       <= cfg_wdata[14:0];
        hvr_pkg::CFG_HYSTERESIS:  cfg_r.hysteresis     <= cfg_wdata[14:0];
        hvr_pkg::CFG_MIN_OPEN:    cfg_r.min_open_ms    <= cfg_wdata[15:0];
        hvr_pkg::CFG_KA_ENABLE:   cfg_r.ka_enable      <= cfg_wdata[0];
        hvr_pkg::CFG_KA_PERIOD:   cfg_r.ka_period_ms   <= cfg_wdata;
        hvr_pkg::CFG_PWM_ENABLE:  cfg_r.pwm_enable     <= cfg_wdata[0];
        hvr_pkg::CFG_PWM_DUTY:    cfg_r.pwm_duty       <= cfg_wdata[7:0];
        hvr_pkg::CFG_PWM_FULL_ON: cfg_r.pwm_full_on_ms <= cfg_wdata[15:0];
        default: begin
        end
      endcase
    end
  end

  // input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (in_ready) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      req_r      <= in_req_type;
      now_r      <= in_now_ms;
      pvalid_r   <= in_pressure_valid;
      pressure_r <= in_pressure;
    end
  end

  hvr_step u_step (
    .cfg            (cfg_r),
    .st             (st_r),
    .req_type       (req_r),
    .now_ms         (now_r),
    .pressure_valid (pvalid_r),
    .pressure       (pressure_r),
    .st_nxt         (st_nxt),
    .flags          (flags)
  );

  // regulator state advances once per item as it moves to the result stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '{reg_en: 1'b0, manual: 1'b0, is_open: 1'b0, drive: hvr_pkg::DRV_LOW,
                last_open: 32'd0, last_kick: 32'd0, held_pressure: 16'sd0};
    end else if (step) begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (advance) begin
      ov_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      drive_r   <= st_nxt.drive;
      duty_r    <= (st_nxt.drive == hvr_pkg::DRV_PWM) ? cfg_r.pwm_duty : 8'd0;
      reg_on_r  <= st_nxt.reg_en;
      manual_r  <= st_nxt.manual;
      refused_r <= flags.refused;
      tripped_r <= flags.tripped;
      latest_r  <= st_nxt.held_pressure;
    end
  end

  assign out_valid             = ov_r;
  assign out_valve_drive       = drive_r;
  assign out_drive_duty        = duty_r;
  assign out_regulator_on      = reg_on_r;
  assign out_manual_active     = manual_r;
  assign out_open_refused      = refused_r;
  assign out_keepalive_tripped = tripped_r;
  assign out_latest_pressure   = latest_r;

  a_open_matches_drive: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.is_open == (st_r.drive != hvr_pkg::DRV_LOW))
    else $error("valve open flag and drive state disagree");

  a_refused_keeps_closed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_open_refused |-> out_valve_drive == hvr_pkg::DRV_LOW)
    else $error("refused opening left the valve driven");

  a_trip_shuts_all: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_keepalive_tripped |->
      !out_regulator_on && !out_manual_active && out_valve_drive == hvr_pkg::DRV_LOW)
    else $error("watchdog trip did not shut the regulator");

  a_duty_only_pwm: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_valve_drive != hvr_pkg::DRV_PWM |-> out_drive_duty == 8'd0)
    else $error("duty reported outside PWM drive");

  a_state_holds_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !step |=> $stable(st_r))
    else $error("regulator state changed without an item");

endmodule
